FILE: hw/rtl/sorted_byte_key_child_table_unit_macros.svh
// Assertion macros for the sorted byte key child table unit.
// Used by the slot table and the top level; expects clk and rst_n in scope.
`ifndef SORTED_BYTE_KEY_CHILD_TABLE_UNIT_MACROS_SVH
`define SORTED_BYTE_KEY_CHILD_TABLE_UNIT_MACROS_SVH

// same-cycle implication
`define SBKCT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sbkct assertion failed");

// next-cycle implication
`define SBKCT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sbkct assertion failed");

`endif

FILE: hw/rtl/sbkct_pkg.sv
// Package for the sorted byte key child table unit.
// Action and status codes, field widths and the result record; no dependencies.
package sbkct_pkg;

    localparam int ENTRIES_DEF      = 32;
    localparam int HANDLE_WIDTH_DEF = 32;

    localparam int ACTION_W = 2;
    localparam int KEY_W    = 8;
    localparam int HANDLE_W = 32;
    localparam int SLOT_W   = 5;
    localparam int COUNT_W  = 6;
    localparam int STATUS_W = 2;

    typedef enum logic [ACTION_W-1:0] {
        ACT_LOOKUP = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_REMOVE = 2'd2
    } action_t;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_SLOT = 2'd2;

    typedef struct packed {
        logic                found;
        logic [SLOT_W-1:0]   hit_slot;
        logic [HANDLE_W-1:0] hit_handle;
        logic [COUNT_W-1:0]  entry_count;
        logic [HANDLE_W-1:0] first_handle;
        logic [HANDLE_W-1:0] last_handle;
        logic [STATUS_W-1:0] status;
    } result_t;

endpackage

FILE: hw/rtl/sorted_byte_key_child_table_unit.sv
// Top level of the sorted byte key child table unit: input register, slot table,
// result register. Depends on sbkct_pkg, sbkct_table and the macro header.
//
//  channel | handshake          | payload
//  --------+--------------------+------------------------------------------------
//  in      | in_valid, in_stall | action, key_byte, child_handle, slot_index
//  out     | out_valid,out_stall| found, hit_slot, hit_handle, entry_count,
//          |                    | first_handle, last_handle, status
//
// One transfer per cycle sustained while out_stall is low; the input register holds the
// transfer, and the result register then captures the table result for it.
// The table compare, priority encode and shift are combinational between the
// input register and the result register.
// Reset clears the entry count and the valid flags; no clearing pass, the unit accepts right after reset.
// A stalled result holds; in_stall rises only when both registers are full.
`include "sorted_byte_key_child_table_unit_macros.svh"

module sorted_byte_key_child_table_unit #(
    parameter int ENTRIES      = sbkct_pkg::ENTRIES_DEF,
    parameter int HANDLE_WIDTH = sbkct_pkg::HANDLE_WIDTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [sbkct_pkg::ACTION_W-1:0]     action,
    input  logic [sbkct_pkg::KEY_W-1:0]        key_byte,
    input  logic [sbkct_pkg::HANDLE_W-1:0]     child_handle,
    input  logic [sbkct_pkg::SLOT_W-1:0]       slot_index,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               found,
    output logic [sbkct_pkg::SLOT_W-1:0]       hit_slot,
    output logic [sbkct_pkg::HANDLE_W-1:0]     hit_handle,
    output logic [sbkct_pkg::COUNT_W-1:0]      entry_count,
    output logic [sbkct_pkg::HANDLE_W-1:0]     first_handle,
    output logic [sbkct_pkg::HANDLE_W-1:0]     last_handle,
    output logic [sbkct_pkg::STATUS_W-1:0]     status
);

    logic                              s0_valid_reg;
    logic [sbkct_pkg::ACTION_W-1:0]    action_reg;
    logic [sbkct_pkg::KEY_W-1:0]       key_reg;
    logic [sbkct_pkg::HANDLE_W-1:0]    handle_reg;
    logic [sbkct_pkg::SLOT_W-1:0]      slot_reg;
    logic                              out_valid_reg;
    sbkct_pkg::result_t                res_reg;
    sbkct_pkg::result_t                res_next;
    logic                              advance;
    logic                              step;

    assign advance  = !out_valid_reg || !out_stall;
    assign step     = s0_valid_reg && advance;
    assign in_stall = s0_valid_reg && !advance;

    sbkct_table #(
        .ENTRIES      (ENTRIES),
        .HANDLE_WIDTH (HANDLE_WIDTH)
    ) u_table (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .action       (action_reg),
        .key_byte     (key_reg),
        .child_handle (handle_reg),
        .slot_index   (slot_reg),
        .result       (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
            begin
                s0_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= step;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall)
        begin
            action_reg <= action;
            key_reg    <= key_byte;
            handle_reg <= child_handle;
            slot_reg   <= slot_index;
        end
        if (step)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign found        = res_reg.found;
    assign hit_slot     = res_reg.hit_slot;
    assign hit_handle   = res_reg.hit_handle;
    assign entry_count  = res_reg.entry_count;
    assign first_handle = res_reg.first_handle;
    assign last_handle  = res_reg.last_handle;
    assign status       = res_reg.status;

    `SBKCT_ASSERT_NOW(a_stall_needs_item, in_stall, s0_valid_reg && out_valid_reg)
    `SBKCT_ASSERT_NEXT(a_step_gives_result, step, out_valid_reg)
    `SBKCT_ASSERT_NEXT(a_held_result_stable, out_valid_reg && out_stall,
        out_valid_reg && $stable(res_reg))

endmodule

FILE: hw/rtl/sbkct_table.sv
// Slot table: sorted key and handle register file with count, parallel compare,
// priority encode and shift. Depends on sbkct_pkg and the macro header.
`include "sorted_byte_key_child_table_unit_macros.svh"

module sbkct_table #(
    parameter int ENTRIES      = sbkct_pkg::ENTRIES_DEF,
    parameter int HANDLE_WIDTH = sbkct_pkg::HANDLE_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                step,
    input  logic [sbkct_pkg::ACTION_W-1:0]      action,
    input  logic [sbkct_pkg::KEY_W-1:0]         key_byte,
    input  logic [sbkct_pkg::HANDLE_W-1:0]      child_handle,
    input  logic [sbkct_pkg::SLOT_W-1:0]        slot_index,
    output sbkct_pkg::result_t                  result
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);

    logic [sbkct_pkg::KEY_W-1:0] key_reg    [ENTRIES];
    logic [sbkct_pkg::KEY_W-1:0] key_next   [ENTRIES];
    logic [HANDLE_WIDTH-1:0]     handle_reg [ENTRIES];
    logic [HANDLE_WIDTH-1:0]     handle_next[ENTRIES];
    logic [CW-1:0]               count_reg;
    logic [CW-1:0]               count_next;

    logic [ENTRIES-1:0]      eq_vec;
    logic [ENTRIES-1:0]      eq_first;
    logic [ENTRIES-1:0]      ge_vec;
    logic [ENTRIES-1:0]      ins_first;
    logic [ENTRIES-1:0]      rm_vec;
    logic [ENTRIES-1:0]      last_sel;
    logic [IW-1:0]           look_idx;
    logic [IW-1:0]           ins_idx;
    logic [HANDLE_WIDTH-1:0] look_handle;
    logic [HANDLE_WIDTH-1:0] last_h;
    logic [HANDLE_WIDTH-1:0] new_handle;
    logic                    full;
    logic                    slot_ok;

    assign full       = (count_reg == CW'(ENTRIES));
    assign slot_ok    = (int'(slot_index) < int'(count_reg));
    assign new_handle = HANDLE_WIDTH'(child_handle);

    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            eq_vec[i] = (i < int'(count_reg)) && (key_reg[i] == key_byte);
            ge_vec[i] = (i >= int'(count_reg)) || (key_byte < key_reg[i]);
            rm_vec[i] = (i >= int'(slot_index));
        end
        eq_first  = eq_vec & (~eq_vec + ENTRIES'(1));
        ins_first = ge_vec & ~(ge_vec << 1);
    end

    always_comb
    begin
        look_idx    = '0;
        ins_idx     = '0;
        look_handle = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (eq_first[i])
            begin
                look_idx    = look_idx | IW'(i);
                look_handle = look_handle | handle_reg[i];
            end
            if (ins_first[i])
            begin
                ins_idx = ins_idx | IW'(i);
            end
        end
    end

    always_comb
    begin
        key_next    = key_reg;
        handle_next = handle_reg;
        count_next  = count_reg;
        case (action)
            sbkct_pkg::ACT_INSERT:
            begin
                if (!full)
                begin
                    if (ge_vec[0])
                    begin
                        key_next[0]    = key_byte;
                        handle_next[0] = new_handle;
                    end
                    for (int i = 1; i < ENTRIES; i++)
                    begin
                        if (ins_first[i])
                        begin
                            key_next[i]    = key_byte;
                            handle_next[i] = new_handle;
                        end
                        else if (ge_vec[i])
                        begin
                            key_next[i]    = key_reg[i-1];
                            handle_next[i] = handle_reg[i-1];
                        end
                    end
                    count_next = count_reg + CW'(1);
                end
            end
            sbkct_pkg::ACT_REMOVE:
            begin
                if (slot_ok)
                begin
                    for (int i = 0; i < ENTRIES - 1; i++)
                    begin
                        if (rm_vec[i])
                        begin
                            key_next[i]    = key_reg[i+1];
                            handle_next[i] = handle_reg[i+1];
                        end
                    end
                    count_next = count_reg - CW'(1);
                end
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    always_comb
    begin
        last_h = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            last_sel[i] = (int'(count_next) == i + 1);
            if (last_sel[i])
            begin
                last_h = last_h | handle_next[i];
            end
        end
    end

    always_comb
    begin
        result              = '0;
        result.entry_count  = sbkct_pkg::COUNT_W'(count_next);
        result.first_handle = (count_next != '0) ? sbkct_pkg::HANDLE_W'(handle_next[0]) : '0;
        result.last_handle  = sbkct_pkg::HANDLE_W'(last_h);
        case (action)
            sbkct_pkg::ACT_LOOKUP:
            begin
                result.found      = |eq_vec;
                result.hit_slot   = sbkct_pkg::SLOT_W'(look_idx);
                result.hit_handle = sbkct_pkg::HANDLE_W'(look_handle);
            end
            sbkct_pkg::ACT_INSERT:
            begin
                if (full)
                begin
                    result.status = sbkct_pkg::ST_FULL;
                end
                else
                begin
                    result.hit_slot = sbkct_pkg::SLOT_W'(ins_idx);
                end
            end
            sbkct_pkg::ACT_REMOVE:
            begin
                result.status = slot_ok ? sbkct_pkg::ST_OK : sbkct_pkg::ST_BAD_SLOT;
            end
            default:
            begin
                result.status = sbkct_pkg::ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (step)
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            key_reg    <= key_next;
            handle_reg <= handle_next;
        end
    end

    `SBKCT_ASSERT_NOW(a_count_bound, 1'b1, int'(count_reg) <= ENTRIES)
    `SBKCT_ASSERT_NEXT(a_full_insert_holds, step && action == sbkct_pkg::ACT_INSERT && full,
        $stable(count_reg))
    `SBKCT_ASSERT_NEXT(a_insert_grows, step && action == sbkct_pkg::ACT_INSERT && !full,
        count_reg == $past(count_reg) + CW'(1))
    `SBKCT_ASSERT_NEXT(a_remove_shrinks, step && action == sbkct_pkg::ACT_REMOVE && slot_ok,
        count_reg == $past(count_reg) - CW'(1))

endmodule
